// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the recency shift list.
// No dependencies; files that assert take this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSL_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define RSL_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/rsl_pkg.sv =====
// Package for the recency shift list: command codes, field widths, empty code.
// No dependencies.
package rsl_pkg;

	localparam int unsigned CMD_W   = 2;
	localparam int unsigned VALUE_W = 8;
	localparam int unsigned INDEX_W = 6;

	localparam logic [VALUE_W-1:0] EMPTY_CODE = 8'hFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 2'd0,
		CMD_READ   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

endpackage

// ===== rtl/recency_shift_list.sv =====
// Recency shift list: DEPTH location codes, newest at position 0.
// Uses rsl_pkg and assert_macros.svh.
//
//  channel | direction | handshake            | words
//  --------+-----------+----------------------+---------------------------
//  in      | input     | in_valid / in_stall  | command, value, index
//  out     | output    | out_valid / out_stall| read_value, hit
//
// Push, unused command, out-of-range read: accept goes straight to ST_DONE, which
// loads the output word, then ST_IDLE takes the next input word; read: ST_READ first
// (one registered list read). Remove: ST_SCAN; one comparator walks the list from the
// oldest entry toward position 0, one entry per cycle, and stops at the first match.
// A finished word holds in ST_DONE while the output register is full and stalled,
// and the input stays stalled meanwhile. Reset empties every entry and the output.
`include "assert_macros.svh"

module recency_shift_list #(
	parameter int unsigned DEPTH = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rsl_pkg::CMD_W-1:0]   command,
	input  logic [rsl_pkg::VALUE_W-1:0] value,
	input  logic [rsl_pkg::INDEX_W-1:0] index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rsl_pkg::VALUE_W-1:0] read_value,
	output logic                        hit
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [rsl_pkg::VALUE_W-1:0]   entries_q [DEPTH];
	logic [PW-1:0]                 ptr_q;
	logic [rsl_pkg::VALUE_W-1:0]   value_q;
	logic [rsl_pkg::VALUE_W-1:0]   res_value_q;
	logic                          res_hit_q;
	logic                          out_valid_q;
	logic [rsl_pkg::VALUE_W-1:0]   read_value_q;
	logic                          hit_q;

	logic                          accept;
	logic                          in_range;
	logic [rsl_pkg::VALUE_W-1:0]   probe;
	logic                          match;
	logic                          out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign in_range  = ({1'b0, index} < (rsl_pkg::INDEX_W + 1)'(DEPTH));
	// Single read port of the list, shared by read and remove.
	assign probe     = entries_q[ptr_q];
	assign match     = (probe == value_q);
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign hit        = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			for (int k = 0; k < DEPTH; k++) begin
				entries_q[k] <= rsl_pkg::EMPTY_CODE;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						value_q     <= value;
						res_value_q <= rsl_pkg::EMPTY_CODE;
						res_hit_q   <= 1'b0;
						state_q     <= ST_DONE;
						case (rsl_pkg::cmd_t'(command))
							rsl_pkg::CMD_PUSH: begin
								// advance every entry one place older
								for (int k = 1; k < DEPTH; k++) begin
									entries_q[k] <= entries_q[k-1];
								end
								entries_q[0] <= value;
							end
							rsl_pkg::CMD_READ: begin
								if (in_range) begin
									ptr_q   <= index[PW-1:0];
									state_q <= ST_READ;
								end
							end
							rsl_pkg::CMD_REMOVE: begin
								ptr_q   <= LAST;
								state_q <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					res_value_q <= probe;
					res_hit_q   <= 1'b1;
					state_q     <= ST_DONE;
				end
				ST_SCAN: begin
					if (match) begin
						// close the gap at ptr_q, empty the newest place
						for (int k = 1; k < DEPTH; k++) begin
							if (PW'(k) <= ptr_q) begin
								entries_q[k] <= entries_q[k-1];
							end
						end
						entries_q[0] <= rsl_pkg::EMPTY_CODE;
						res_hit_q    <= 1'b1;
						state_q      <= ST_DONE;
					end else if (ptr_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						ptr_q <= ptr_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// output register: load a finished word, drop a taken one
			if (state_q == ST_DONE && out_free) begin
				out_valid_q  <= 1'b1;
				read_value_q <= res_value_q;
				hit_q        <= res_hit_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`RSL_ASSERT_NXT(a_push_lands, clk, arst_n, accept && command == rsl_pkg::CMD_PUSH, entries_q[0] == $past(value))
	`RSL_ASSERT_IMP(a_scan_ptr, clk, arst_n, state_q == ST_SCAN, ptr_q <= LAST)
	`RSL_ASSERT_IMP(a_data_hit, clk, arst_n, out_valid_q && read_value_q != rsl_pkg::EMPTY_CODE, hit_q)
	`RSL_ASSERT_NXT(a_one_word, clk, arst_n, accept, in_stall)

endmodule
